// ===== rtl/iprc_pkg.sv =====
`default_nettype none

package iprc_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch a new item and restart the scan
    logic scan;      // step the key scan by one entry
    logic sel_hit;   // take the matching entry as the target slot
    logic sel_miss;  // take the replacement pointer as the target slot
    logic wr;        // write key and payload into the target slot
    logic rd;        // read the payload of the target slot
    logic resp;      // load the result registers and strobe them
  } iprc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ip_zero;   // latched address is zero
    logic insert;    // latched command is an insert
    logic match;     // the entry under compare holds the address
    logic last;      // the entry under compare is the final one
  } iprc_sts_t;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/iprc_ctrl.sv =====
`default_nettype none

module iprc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire iprc_pkg::iprc_sts_t sts_i,
  output iprc_pkg::iprc_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (sts_i.ip_zero) begin
          state_d = StFin;
        end else if (sts_i.match) begin
          cmd_o.sel_hit = 1'b1;
          state_d = (sts_i.insert == iprc_pkg::CmdInsert) ? StWrite : StRead;
        end else if (sts_i.last) begin
          cmd_o.sel_miss = 1'b1;
          state_d = (sts_i.insert == iprc_pkg::CmdInsert) ? StWrite : StFin;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      StWrite: begin
        cmd_o.wr = 1'b1;
        state_d  = StFin;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StFin;
      end
      StFin: begin
        cmd_o.resp = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iprc_dp.sv =====
`default_nettype none

module iprc_dp #(
  parameter int unsigned ENTRIES      = 24,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire iprc_pkg::iprc_cmd_t     cmd_i,
  output iprc_pkg::iprc_sts_t          sts_o,
  input  wire logic                    op_i,
  input  wire logic [31:0]             ip_i,
  input  wire logic [PAYLOAD_BITS-1:0] payload_in_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [PAYLOAD_BITS-1:0]      payload_out_o,
  output logic                         is_private_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam logic [7:0] OctTen     = 8'd10;
  localparam logic [7:0] OctC192    = 8'd192;
  localparam logic [7:0] OctC168    = 8'd168;
  localparam logic [7:0] OctC172    = 8'd172;
  localparam logic [7:0] OctLoop    = 8'd127;
  localparam logic [7:0] OctC169    = 8'd169;
  localparam logic [7:0] OctC254    = 8'd254;
  localparam logic [7:0] OctCgn     = 8'd100;
  localparam logic [7:0] OctMcast   = 8'd224;

  // Non-public range check on the first two octets.
  function automatic logic non_public(input logic [31:0] addr);
    logic [7:0] a;
    logic [7:0] b;
    a = addr[31:24];
    b = addr[23:16];
    non_public = (a == OctTen)
              || (a == OctC192 && b == OctC168)
              || (a == OctC172 && b[7:4] == 4'h1)
              || (a == OctLoop)
              || (a == OctC169 && b == OctC254)
              || (a == OctCgn && b[7:6] == 2'b01)
              || (a == 8'd0)
              || (a >= OctMcast);
  endfunction

  // Item registers.
  logic                    op_q;
  logic [31:0]             ip_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // Stores and their read registers.
  logic [31:0]             key_mem [ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
  logic [ENTRIES-1:0]      valid_q;
  logic [31:0]             key_rd_q;
  logic                    vld_rd_q;
  logic [PAYLOAD_BITS-1:0] pay_rd_q;

  // Scan and slot control.
  logic [IdxW-1:0] scan_q;
  logic            scan_done_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_ok_q;
  logic [IdxW-1:0] slot_q;
  logic [IdxW-1:0] ptr_q;
  logic            hit_q;
  logic            issue;

  assign issue = cmd_i.scan && !scan_done_q;

  assign sts_o.ip_zero = (ip_q == 32'd0);
  assign sts_o.insert  = op_q;
  assign sts_o.match   = cmp_ok_q && vld_rd_q && (key_rd_q == ip_q);
  assign sts_o.last    = cmp_ok_q && (cmp_idx_q == LastIdx);

  // Latch the item when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      ip_q  <= ip_i;
      pay_q <= payload_in_i;
    end
  end

  // Key and payload memories: one write port, registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      key_mem[slot_q] <= ip_q;
      pay_mem[slot_q] <= pay_q;
    end
    if (issue) begin
      key_rd_q <= key_mem[scan_q];
    end
    if (cmd_i.rd) begin
      pay_rd_q <= pay_mem[slot_q];
    end
  end

  // Valid bits, scan sequencing, target slot and replacement pointer.
  // No scan step is issued in the load cycle, so the compare flag drops there too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      vld_rd_q    <= 1'b0;
      scan_q      <= '0;
      scan_done_q <= 1'b0;
      cmp_idx_q   <= '0;
      cmp_ok_q    <= 1'b0;
      slot_q      <= '0;
      ptr_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      cmp_ok_q <= issue;
      if (cmd_i.load) begin
        scan_q      <= '0;
        scan_done_q <= 1'b0;
        hit_q       <= 1'b0;
      end else if (issue) begin
        vld_rd_q  <= valid_q[scan_q];
        cmp_idx_q <= scan_q;
        if (scan_q == LastIdx) begin
          scan_done_q <= 1'b1;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (cmd_i.sel_hit) begin
        slot_q <= cmp_idx_q;
        hit_q  <= 1'b1;
      end
      if (cmd_i.sel_miss) begin
        slot_q <= ptr_q;
        hit_q  <= 1'b0;
      end
      if (cmd_i.wr) begin
        valid_q[slot_q] <= 1'b1;
        if (!hit_q) begin
          ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
        end
      end
    end
  end

  // Result registers, strobed for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      hit_o         <= hit_q;
      payload_out_o <= (hit_q && op_q == iprc_pkg::CmdLookup) ? pay_rd_q : '0;
      is_private_o  <= non_public(ip_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ip_result_cache_round_robin_core.sv =====
// Steps: key scan (skipped for a zero address), a write or read if needed, then the result;
// the sequential key scan reads one entry per cycle from the key memory.
// Throughput: one item at a time, a new item is taken only while busy_o is low.
// Reset clears all valid bits, the replacement pointer and the controller at once;
// the receiver cannot stall, each result is shown for exactly one cycle.
`default_nettype none

module ip_result_cache_round_robin_core #(
  parameter int unsigned ENTRIES      = 24,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    cmd_i,
  input  wire logic [31:0]             ip_i,
  input  wire logic [PAYLOAD_BITS-1:0] payload_in_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [PAYLOAD_BITS-1:0]      payload_out_o,
  output logic                         is_private_o
);

  iprc_pkg::iprc_cmd_t ctl_cmd;
  iprc_pkg::iprc_sts_t ctl_sts;

  // Sequencer for scan, update and response.
  iprc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (ctl_sts),
    .cmd_o   (ctl_cmd)
  );

  // Stores, comparator and result registers.
  iprc_dp #(
    .ENTRIES      (ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .sts_o         (ctl_sts),
    .op_i          (cmd_i),
    .ip_i          (ip_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .payload_out_o (payload_out_o),
    .is_private_o  (is_private_o)
  );

endmodule

`default_nettype wire
